FILE: sv/emulated_memory_stack_unit_macros.svh
// Assertion macros shared by the block.
`ifndef EMULATED_MEMORY_STACK_UNIT_MACROS_SVH
`define EMULATED_MEMORY_STACK_UNIT_MACROS_SVH

`ifndef SYNTH
// Check prop on every clock edge outside reset.
`define EMSU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check prop on every clock edge, reset included.
`define EMSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EMSU_ASSERT(lbl, clk, rstn, prop, msg)
`define EMSU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/emsu_pkg.sv
package emsu_pkg;

  typedef enum logic [2:0] {
    OP_READ8  = 3'd0,
    OP_READ32 = 3'd1,
    OP_WRITE8 = 3'd2,
    OP_WRITE32 = 3'd3,
    OP_PUSH   = 3'd4,
    OP_POP    = 3'd5,
    OP_CALL   = 3'd6,
    OP_RET    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_ADDR  = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_UNDER = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FINISH
  } st_e;

  typedef enum logic [1:0] {
    REG_SP_FLOOR   = 2'd0,
    REG_SP_CEILING = 2'd1,
    REG_START_SP   = 2'd2,
    REG_START_IP   = 2'd3
  } reg_e;

  localparam logic [31:0] StackLimitReset = 32'h0000_0000;
  localparam logic [31:0] StackBaseReset  = 32'h0001_0000;
  localparam logic [31:0] StartSpReset    = 32'h0001_0000;
  localparam logic [31:0] StartIpReset    = 32'h0000_0000;
  localparam logic [31:0] WordBytes       = 32'd4;
  localparam logic [31:0] CallLength      = 32'd5;
  localparam logic [31:0] ByteMask        = 32'h0000_00FF;

  // Decoded operation, checked against bounds and stack limits.
  typedef struct packed {
    op_e         kind;
    fault_e      fault;
    logic        mem_we;
    logic        is_word;
    logic [31:0] acc_addr;
    logic [31:0] wdata;
    logic [31:0] sp_next;
    logic [31:0] ip_next;
  } exec_t;

  // Operation held between the bank access and the result.
  typedef struct packed {
    op_e         kind;
    fault_e      fault;
    logic [1:0]  lane;
    logic [31:0] sp_next;
    logic [31:0] ip_next;
  } pend_t;

  // Pointer loads from the configuration port.
  typedef struct packed {
    logic        sp_we;
    logic        ip_we;
    logic [31:0] value;
  } cfg_load_t;

endpackage

FILE: sv/emsu_if.sv
interface emsu_in_if import emsu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [31:0]        address;
  logic [31:0]        write_value;
  logic signed [31:0] rel_offset;

  modport source (output valid, kind, address, write_value, rel_offset, input ready);
  modport sink (input valid, kind, address, write_value, rel_offset, output ready);
endinterface

interface emsu_out_if import emsu_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  fault;
  logic [31:0] stack_now;
  logic [31:0] ip_now;

  modport source (output valid, read_data, fault, stack_now, ip_now, input ready);
  modport sink (input valid, read_data, fault, stack_now, ip_now, output ready);
endinterface

FILE: sv/emsu_ram.sv
module emsu_ram #(
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/emsu_cfg.sv
module emsu_cfg import emsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] sp_floor_o,
  output logic [31:0] sp_ceiling_o,
  output cfg_load_t   load_o
);

  logic [31:0] limit_q, limit_d;
  logic [31:0] base_q, base_d;
  logic [31:0] start_sp_q, start_sp_d;
  logic [31:0] start_ip_q, start_ip_d;
  logic        wr;
  reg_e        idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_e'(paddr[3:2]);

  always_comb begin
    limit_d      = limit_q;
    base_d       = base_q;
    start_sp_d   = start_sp_q;
    start_ip_d   = start_ip_q;
    load_o.sp_we = 1'b0;
    load_o.ip_we = 1'b0;
    load_o.value = pwdata;
    if (wr) begin
      unique case (idx)
        REG_SP_FLOOR:   limit_d = pwdata;
        REG_SP_CEILING: base_d = pwdata;
        REG_START_SP: begin
          start_sp_d   = pwdata;
          load_o.sp_we = 1'b1;
        end
        REG_START_IP: begin
          start_ip_d   = pwdata;
          load_o.ip_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SP_FLOOR:   prdata = limit_q;
      REG_SP_CEILING: prdata = base_q;
      REG_START_SP:   prdata = start_sp_q;
      REG_START_IP:   prdata = start_ip_q;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= StackLimitReset;
      base_q     <= StackBaseReset;
      start_sp_q <= StartSpReset;
      start_ip_q <= StartIpReset;
    end else begin
      limit_q    <= limit_d;
      base_q     <= base_d;
      start_sp_q <= start_sp_d;
      start_ip_q <= start_ip_d;
    end
  end

  assign sp_floor_o   = limit_q;
  assign sp_ceiling_o = base_q;

endmodule

FILE: sv/emsu_exec.sv
module emsu_exec import emsu_pkg::*; #(
  parameter int unsigned MEMORY_BYTES = 65536
) (
  input  logic [2:0]         kind_i,
  input  logic [31:0]        address_i,
  input  logic [31:0]        write_value_i,
  input  logic signed [31:0] rel_offset_i,
  input  logic [31:0]        sp_i,
  input  logic [31:0]        ip_i,
  input  logic [31:0]        sp_floor_i,
  input  logic [31:0]        sp_ceiling_i,
  output exec_t              exec_o
);

  localparam logic [32:0] MemLimit = 33'(MEMORY_BYTES);

  logic [31:0] sp_dec;
  logic [31:0] ip_ret;
  logic        push_fault_over;
  logic        push_word_ok;
  logic        pop_word_ok;
  logic        addr_byte_ok;
  logic        addr_word_ok;
  fault_e      push_fault;
  fault_e      pop_fault;

  function automatic logic word_ok(input logic [31:0] a);
    word_ok = ({1'b0, a} + 33'd3) < MemLimit;
  endfunction

  assign sp_dec          = sp_i - WordBytes;
  assign ip_ret          = ip_i + CallLength;
  assign push_fault_over = sp_dec < sp_floor_i;
  assign push_word_ok    = word_ok(sp_dec);
  assign pop_word_ok     = word_ok(sp_i);
  assign addr_byte_ok    = {1'b0, address_i} < MemLimit;
  assign addr_word_ok    = word_ok(address_i);

  always_comb begin
    priority if (push_fault_over) begin
      push_fault = FAULT_OVER;
    end else if (!push_word_ok) begin
      push_fault = FAULT_ADDR;
    end else begin
      push_fault = FAULT_OK;
    end
    priority if (sp_i > sp_ceiling_i) begin
      pop_fault = FAULT_UNDER;
    end else if (!pop_word_ok) begin
      pop_fault = FAULT_ADDR;
    end else begin
      pop_fault = FAULT_OK;
    end
  end

  always_comb begin
    exec_o.kind     = op_e'(kind_i);
    exec_o.fault    = FAULT_OK;
    exec_o.mem_we   = 1'b0;
    exec_o.is_word  = 1'b1;
    exec_o.acc_addr = address_i;
    exec_o.wdata    = write_value_i;
    exec_o.sp_next  = sp_i;
    exec_o.ip_next  = ip_i;
    unique case (op_e'(kind_i))
      OP_READ8: begin
        exec_o.is_word = 1'b0;
        exec_o.fault   = addr_byte_ok ? FAULT_OK : FAULT_ADDR;
      end
      OP_READ32: begin
        exec_o.fault = addr_word_ok ? FAULT_OK : FAULT_ADDR;
      end
      OP_WRITE8: begin
        exec_o.is_word = 1'b0;
        exec_o.wdata   = write_value_i & ByteMask;
        exec_o.fault   = addr_byte_ok ? FAULT_OK : FAULT_ADDR;
        exec_o.mem_we  = addr_byte_ok;
      end
      OP_WRITE32: begin
        exec_o.fault  = addr_word_ok ? FAULT_OK : FAULT_ADDR;
        exec_o.mem_we = addr_word_ok;
      end
      OP_PUSH, OP_CALL: begin
        exec_o.acc_addr = sp_dec;
        exec_o.fault    = push_fault;
        exec_o.mem_we   = (push_fault == FAULT_OK);
        if (push_fault == FAULT_OK) begin
          exec_o.sp_next = sp_dec;
        end
        if (op_e'(kind_i) == OP_CALL) begin
          exec_o.wdata = ip_ret;
          if (push_fault == FAULT_OK) begin
            exec_o.ip_next = ip_ret + $unsigned(rel_offset_i);
          end
        end
      end
      OP_POP, OP_RET: begin
        exec_o.acc_addr = sp_i;
        exec_o.fault    = pop_fault;
        if (pop_fault == FAULT_OK) begin
          exec_o.sp_next = sp_i + WordBytes;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/emulated_memory_stack_unit.sv
// Memory and stack unit of an emulated x86: byte memory of MEMORY_BYTES bytes
// split over four byte-wide banks, so that any 8-bit or 32-bit little-endian
// access, aligned or not, reads or writes each bank at most once. When an
// operation is taken, its bounds and stack limits are checked and the bank
// access is issued; in the finish state that follows, the registered bank
// data is assembled and the stack and instruction pointers are updated.
// A new operation is taken while the previous result still waits, as long as
// the output is taken by then. After reset a clearing pass zeroes all four
// banks, one row per cycle, over all MEMORY_BYTES/4 rows (rounded up); no
// operation is taken during it, while register writes are. A faulting
// operation returns its fault code with zero data and changes no state.
module emulated_memory_stack_unit import emsu_pkg::*; #(
  parameter int unsigned MEMORY_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  emsu_in_if.sink     in_ch,
  emsu_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "emulated_memory_stack_unit_macros.svh"

  localparam int unsigned Rows = (MEMORY_BYTES + 3) / 4;
  localparam int unsigned RowW = $clog2(Rows);

  st_e         state_q, state_d;
  logic [RowW-1:0] clr_q, clr_d;
  logic [31:0] sp_q, sp_d;
  logic [31:0] ip_q, ip_d;
  pend_t       pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic [1:0]  out_fault_q, out_fault_d;
  logic [31:0] out_sp_q, out_sp_d;
  logic [31:0] out_ip_q, out_ip_d;

  logic [31:0] sp_floor;
  logic [31:0] sp_ceiling;
  cfg_load_t   cfg_load;
  exec_t       ex;
  logic        accept;
  logic        clearing;
  logic [31:0] bank_word;
  logic [63:0] word_pair;
  logic [31:0] rot_word;
  logic        pend_ok;

  emsu_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .sp_floor_o   (sp_floor),
    .sp_ceiling_o (sp_ceiling),
    .load_o       (cfg_load)
  );

  emsu_exec #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_exec (
    .kind_i        (in_ch.kind),
    .address_i     (in_ch.address),
    .write_value_i (in_ch.write_value),
    .rel_offset_i  (in_ch.rel_offset),
    .sp_i          (sp_q),
    .ip_i          (ip_q),
    .sp_floor_i    (sp_floor),
    .sp_ceiling_i  (sp_ceiling),
    .exec_o        (ex)
  );

  assign clearing    = (state_q == ST_CLEAR);
  assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]      off;
    logic [31:0]     addr_sum;
    logic [RowW-1:0] row;
    logic            we;
    logic [RowW-1:0] waddr;
    logic [7:0]      wdata;
    logic [7:0]      rdata;

    // Byte k of the word lands in bank (addr + k) mod 4.
    assign off      = 2'(b) - ex.acc_addr[1:0];
    assign addr_sum = ex.acc_addr + {30'd0, off};
    assign row      = addr_sum[RowW+1:2];
    assign we       = clearing ||
                      (accept && ex.mem_we && (ex.is_word || off == 2'd0));
    assign waddr    = clearing ? clr_q : row;
    assign wdata    = clearing ? 8'd0 : 8'(ex.wdata >> {off, 3'b000});

    emsu_ram #(
      .DEPTH (Rows)
    ) u_ram (
      .clk_i,
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (accept),
      .raddr_i (row),
      .rdata_o (rdata)
    );

    assign bank_word[8*b +: 8] = rdata;
  end

  // Rotate bank order into byte order of the access.
  assign word_pair = {bank_word, bank_word} >> {pend_q.lane, 3'b000};
  assign rot_word  = word_pair[31:0];
  assign pend_ok   = (pend_q.fault == FAULT_OK);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    sp_d        = sp_q;
    ip_d        = ip_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_fault_d = out_fault_q;
    out_sp_d    = out_sp_q;
    out_ip_d    = out_ip_q;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == RowW'(Rows - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          pend_d.kind    = ex.kind;
          pend_d.fault   = ex.fault;
          pend_d.lane    = ex.acc_addr[1:0];
          pend_d.sp_next = ex.sp_next;
          pend_d.ip_next = ex.ip_next;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_valid_d = 1'b1;
        out_fault_d = pend_q.fault;
        out_sp_d    = pend_q.sp_next;
        out_ip_d    = pend_q.ip_next;
        out_data_d  = '0;
        if (pend_ok) begin
          unique case (pend_q.kind)
            OP_READ8:                      out_data_d = {24'd0, rot_word[7:0]};
            OP_READ32, OP_POP, OP_RET:     out_data_d = rot_word;
            default:                       out_data_d = '0;
          endcase
          if (pend_q.kind == OP_RET) begin
            out_ip_d = rot_word;
          end
        end
        sp_d    = out_sp_d;
        ip_d    = out_ip_d;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // The user must write registers only while no operation is in flight; the block does not enforce it.
    if (cfg_load.sp_we) begin
      sp_d = cfg_load.value;
    end
    if (cfg_load.ip_we) begin
      ip_d = cfg_load.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sp_q        <= StartSpReset;
      ip_q        <= StartIpReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      ip_q        <= ip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q      <= pend_d;
    out_data_q  <= out_data_d;
    out_fault_q <= out_fault_d;
    out_sp_q    <= out_sp_d;
    out_ip_q    <= out_ip_d;
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.read_data = out_data_q;
  assign out_ch.fault     = out_fault_q;
  assign out_ch.stack_now = out_sp_q;
  assign out_ch.ip_now    = out_ip_q;

  `EMSU_ASSERT(a_accept_then_finish, clk_i, rst_ni,
    accept |=> (state_q == ST_FINISH), "transfer in did not move to finish")
  `EMSU_ASSERT(a_finish_gives_result, clk_i, rst_ni,
    (state_q == ST_FINISH) |=> (out_valid_q && state_q == ST_IDLE),
    "finish did not produce a result")
  `EMSU_ASSERT_ALWAYS(a_no_take_while_clearing, clk_i,
    clearing |-> !in_ch.ready, "operation taken during clearing pass")
  `EMSU_ASSERT(a_fault_zero_data, clk_i, rst_ni,
    out_valid_q |-> (out_fault_q == FAULT_OK || out_data_q == 32'd0),
    "faulting result carries data")

endmodule

FILE: tb/emulated_memory_stack_unit_tb.sv
`timescale 1ns / 100ps

module emulated_memory_stack_unit_tb;
  import emsu_pkg::*;

  localparam int unsigned MemBytes      = 65536;
  localparam int          HoldCycles    = 240;
  localparam int          WatchdogLimit = 80000;
  localparam int          RoundItems    = 200;
  localparam int          Rounds        = 8;

  typedef struct packed {
    logic [31:0] data;
    fault_e      fault;
    logic [31:0] sp;
    logic [31:0] ip;
  } op_result_t;

  // Tracks memory, both pointers and the stack bounds; queues the result of
  // every accepted operation and checks results against them in order.
  class mem_stack_tracker;
    logic [7:0]  mem [MemBytes];
    logic [31:0] sp;
    logic [31:0] ip;
    logic [31:0] limit;
    logic [31:0] base;
    op_result_t  expected_q[$];
    int          mismatches;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      limit      = StackLimitReset;
      base       = StackBaseReset;
      sp         = StartSpReset;
      ip         = StartIpReset;
      mismatches = 0;
    endfunction

    function void write_reg(reg_e idx, logic [31:0] value);
      case (idx)
        REG_SP_FLOOR:   limit = value;
        REG_SP_CEILING: base = value;
        REG_START_SP:   sp = value;
        REG_START_IP:   ip = value;
        default: ;
      endcase
    endfunction

    // All four bytes must lie below the top; no wrap past 2^32.
    function bit word_fits(logic [31:0] a);
      logic [32:0] last;
      last = {1'b0, a} + 33'd3;
      return last < 33'(MemBytes);
    endfunction

    function logic [31:0] load_word(logic [31:0] a);
      return {mem[a + 3], mem[a + 2], mem[a + 1], mem[a]};
    endfunction

    function void store_word(logic [31:0] a, logic [31:0] v);
      for (int b = 0; b < 4; b++) mem[a + b] = 8'((v >> (8 * b)) & ByteMask);
    endfunction

    function fault_e push_word(logic [31:0] v);
      logic [31:0] nxt;
      nxt = sp - WordBytes;
      if (nxt < limit) return FAULT_OVER;
      if (!word_fits(nxt)) return FAULT_ADDR;
      store_word(nxt, v);
      sp = nxt;
      return FAULT_OK;
    endfunction

    function fault_e pop_word(output logic [31:0] v);
      v = '0;
      if (sp > base) return FAULT_UNDER;
      if (!word_fits(sp)) return FAULT_ADDR;
      v = load_word(sp);
      sp = sp + WordBytes;
      return FAULT_OK;
    endfunction

    function void take_op(op_e kind, logic [31:0] addr, logic [31:0] wval, logic [31:0] rel);
      op_result_t  r;
      logic [31:0] v;
      r.data  = '0;
      r.fault = FAULT_OK;
      case (kind)
        OP_READ8: begin
          if (addr < MemBytes) r.data = {24'h0, mem[addr]};
          else r.fault = FAULT_ADDR;
        end
        OP_READ32: begin
          if (word_fits(addr)) r.data = load_word(addr);
          else r.fault = FAULT_ADDR;
        end
        OP_WRITE8: begin
          if (addr < MemBytes) mem[addr] = 8'(wval & ByteMask);
          else r.fault = FAULT_ADDR;
        end
        OP_WRITE32: begin
          if (word_fits(addr)) store_word(addr, wval);
          else r.fault = FAULT_ADDR;
        end
        OP_PUSH: r.fault = push_word(wval);
        OP_POP: begin
          r.fault = pop_word(v);
          if (r.fault == FAULT_OK) r.data = v;
        end
        OP_CALL: begin
          r.fault = push_word(ip + CallLength);
          if (r.fault == FAULT_OK) ip = ip + rel + CallLength;
        end
        default: begin
          r.fault = pop_word(v);
          if (r.fault == FAULT_OK) begin
            r.data = v;
            ip     = v;
          end
        end
      endcase
      r.sp = sp;
      r.ip = ip;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] data, logic [1:0] fault, logic [31:0] sp_o,
                               logic [31:0] ip_o);
      op_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no operation outstanding: read_data %h fault %0d", data, fault);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $error("read_data: expected %h, actual %h", e.data, data);
        mismatches++;
      end
      if (fault !== e.fault) begin
        $error("fault: expected %0d, actual %0d", e.fault, fault);
        mismatches++;
      end
      if (sp_o !== e.sp) begin
        $error("stack_now: expected %h, actual %h", e.sp, sp_o);
        mismatches++;
      end
      if (ip_o !== e.ip) begin
        $error("ip_now: expected %h, actual %h", e.ip, ip_o);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit steady;
  bit hold_req;
  int idle_cycles;

  mem_stack_tracker tracker;

  emsu_in_if  in_if ();
  emsu_out_if out_if ();

  emulated_memory_stack_unit #(
    .MEMORY_BYTES(MemBytes)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Check results before noting a new operation: a result always belongs
  // to an operation taken at an earlier edge.
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      tracker.check_result(out_if.read_data, out_if.fault, out_if.stack_now, out_if.ip_now);
    end
    if (in_if.valid && in_if.ready) begin
      tracker.take_op(op_e'(in_if.kind), in_if.address, in_if.write_value, in_if.rel_offset);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("emulated_memory_stack_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_if.ready = steady || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  task automatic send_op(op_e kind, logic [31:0] addr, logic [31:0] wval, logic [31:0] rel);
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 99) < 27) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.kind        = kind;
    in_if.address     = addr;
    in_if.write_value = wval;
    in_if.rel_offset  = rel;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic random_round(int n, bit with_hold);
    op_e         kind;
    logic [31:0] addr;
    logic [31:0] rel;
    int          sel;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 60) hold_req = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 50) kind = op_e'(OP_PUSH + $urandom_range(0, 3));
      else if (sel < 90) kind = op_e'(OP_READ8 + $urandom_range(0, 3));
      else kind = op_e'($urandom_range(0, 7));
      sel = $urandom_range(0, 99);
      if (sel < 40) addr = tracker.sp + $urandom_range(0, 16) - 8;
      else if (sel < 65) addr = $urandom_range(0, 'h3FF);
      else if (sel < 80) addr = MemBytes - 16 + $urandom_range(0, 31);
      else if (sel < 90) addr = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else addr = $urandom;
      rel = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64) - 32;
      send_op(kind, addr, $urandom, rel);
    end
  endtask

  initial begin
    logic [31:0] lo;
    logic [31:0] span;
    tracker           = new();
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.kind        = OP_READ8;
    in_if.address     = '0;
    in_if.write_value = '0;
    in_if.rel_offset  = '0;
    steady            = 1'b0;
    hold_req          = 1'b0;
    idle_cycles       = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: memory edges, word wrap, stack top past the memory.
    send_op(OP_WRITE32, 32'h0000_0000, 32'hFFFF_FFFF, '0);
    send_op(OP_READ8,   32'h0000_0000, '0, '0);
    send_op(OP_WRITE8,  32'h0000_FFFF, 32'h1234_5678, '0);
    send_op(OP_READ8,   32'h0000_FFFF, '0, '0);
    send_op(OP_READ8,   32'h0001_0000, '0, '0);
    send_op(OP_WRITE32, 32'h0000_FFFC, 32'hA5A5_5A5A, '0);
    send_op(OP_READ32,  32'h0000_FFFD, '0, '0);
    send_op(OP_READ32,  32'hFFFF_FFFF, '0, '0);
    send_op(OP_PUSH,    '0, 32'hDEAD_BEEF, '0);
    send_op(OP_CALL,    '0, '0, 32'h7FFF_FFFF);
    send_op(OP_RET,     '0, '0, '0);
    send_op(OP_CALL,    '0, '0, 32'h8000_0000);
    send_op(OP_POP,     '0, '0, '0);
    send_op(OP_POP,     '0, '0, '0);
    send_op(OP_POP,     '0, '0, '0);
    send_op(OP_RET,     '0, '0, '0);

    // Tight window: underflow, overflow, call with instruction pointer wrap.
    drain();
    set_reg(REG_SP_FLOOR,   32'h0000_FFF8);
    set_reg(REG_SP_CEILING, 32'h0000_FFF8);
    set_reg(REG_START_SP,   32'h0000_FFFC);
    set_reg(REG_START_IP,   32'hFFFF_FFFF);
    send_op(OP_POP,  '0, '0, '0);
    send_op(OP_RET,  '0, '0, '0);
    send_op(OP_PUSH, '0, 32'h0000_0000, '0);
    send_op(OP_PUSH, '0, 32'h1111_1111, '0);
    send_op(OP_CALL, '0, '0, 32'hFFFF_FFFF);
    send_op(OP_POP,  '0, '0, '0);
    send_op(OP_CALL, '0, '0, 32'hFFFF_FFFF);

    // Stack pointer wrap below zero, and a pop that straddles the top.
    drain();
    set_reg(REG_SP_FLOOR,   32'h0000_0000);
    set_reg(REG_SP_CEILING, 32'hFFFF_FFFF);
    set_reg(REG_START_SP,   32'h0000_0000);
    send_op(OP_PUSH, '0, 32'h2222_2222, '0);
    drain();
    set_reg(REG_START_SP, 32'h0000_FFFE);
    send_op(OP_POP, '0, '0, '0);

    for (int r = 0; r < Rounds; r++) begin
      drain();
      steady = (r == 3);
      case (r)
        0: begin
          set_reg(REG_SP_FLOOR,   StackLimitReset);
          set_reg(REG_SP_CEILING, StackBaseReset);
          set_reg(REG_START_SP,   StartSpReset);
          set_reg(REG_START_IP,   StartIpReset);
        end
        1: begin
          set_reg(REG_SP_FLOOR,   32'hFFFF_FFFF);
          set_reg(REG_SP_CEILING, 32'hFFFF_FFFF);
          set_reg(REG_START_SP,   $urandom_range(0, MemBytes - 1));
          set_reg(REG_START_IP,   32'hFFFF_FFFF);
        end
        2: begin
          set_reg(REG_SP_FLOOR,   32'h0000_0000);
          set_reg(REG_SP_CEILING, 32'h0000_0000);
          set_reg(REG_START_SP,   $urandom_range(0, 64));
          set_reg(REG_START_IP,   $urandom);
        end
        default: begin
          // Small stack window so random push/pop walks hit both ends.
          lo   = (r == Rounds - 1) ? MemBytes - $urandom_range(4, 40)
                                   : $urandom_range(0, MemBytes - 64);
          span = $urandom_range(8, 96);
          set_reg(REG_SP_FLOOR,   lo);
          set_reg(REG_SP_CEILING, lo + span);
          set_reg(REG_START_SP,   lo + $urandom_range(0, span));
          set_reg(REG_START_IP,   $urandom);
        end
      endcase
      random_round(RoundItems, r == 4);
    end

    drain();
    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
      $display("emulated_memory_stack_unit_tb: done, clean");
    end else begin
      $display("emulated_memory_stack_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
